// ===== rtl/ecdm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eval cache package
// Shared types and constants for the direct-mapped evaluation score cache.
// ----------------------------------------------------------------------------
package ecdm_pkg;

    localparam int DefaultDepth = 4096;
    localparam int QueueDepth   = 4;

    localparam int EntriesWidth = 13;
    localparam int ScoreWidth   = 16;
    localparam int TagWidth     = 32;

    localparam logic [EntriesWidth-1:0]      EntriesReset = 13'd4096;
    localparam logic signed [ScoreWidth-1:0] MarkerReset  = 16'sh8000;

    // register select values, decoded on paddr[2]
    localparam logic RegEntries = 1'b0;
    localparam logic RegMarker  = 1'b1;

    typedef enum logic [1:0] {
        REQ_PROBE = 2'd0,
        REQ_SAVE  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef struct packed {
        logic [1:0]                   req_type;
        logic [63:0]                  key;
        logic signed [ScoreWidth-1:0] score_in;
    } t_in_beat;

    typedef struct packed {
        logic                         hit;
        logic signed [ScoreWidth-1:0] score_out;
    } t_out_beat;

    // command handed from the front to the back, slot travels beside it
    typedef struct packed {
        t_req                         req;
        logic [TagWidth-1:0]          tag;
        logic signed [ScoreWidth-1:0] score;
    } t_cmd;

    typedef struct packed {
        logic [TagWidth-1:0]          tag;
        logic signed [ScoreWidth-1:0] score;
    } t_entry;

endpackage

// ===== rtl/ecdm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eval cache command queue
// Small register fifo between the classifying front and the table back.
// ----------------------------------------------------------------------------
module ecdm_queue #(
    parameter int WIDTH = 8,
    parameter int QD    = ecdm_pkg::QueueDepth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PW = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW = $clog2(QD + 1);

    logic [WIDTH-1:0] r_slots [QD];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(QD - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(QD - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_slots[r_rd_ptr];
    assign o_full  = (r_count == CW'(QD));
    assign o_empty = (r_count == '0);

endmodule

// ===== rtl/ecdm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eval cache front
// Takes request beats, forms the tag and the multiply-high slot index.
// ----------------------------------------------------------------------------
module ecdm_front #(
    parameter int DEPTH = ecdm_pkg::DefaultDepth,
    parameter int NW    = $clog2(DEPTH + 1),
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ecdm_pkg::t_in_beat   i_in_beat,
    input  logic [NW-1:0]        i_slots,
    input  logic                 i_init_busy,
    input  logic                 i_q_full,
    output logic                 o_push,
    output ecdm_pkg::t_cmd       o_cmd,
    output logic [AW-1:0]        o_slot
);
    localparam int PW = 32 + NW;

    logic           r_p_valid, n_p_valid;
    logic [PW-1:0]  r_p_lo;
    logic [PW-1:0]  r_p_hi;
    ecdm_pkg::t_cmd r_p_cmd;

    logic           accept;
    logic [PW-1:0]  lo_prod;
    logic [PW-1:0]  hi_prod;
    logic [PW:0]    mid;

    assign o_in_stall = i_init_busy | (r_p_valid & i_q_full);
    assign accept     = i_in_valid & ~o_in_stall;
    assign o_push     = r_p_valid & ~i_q_full;

    // the two 32 x n partial products of key * n
    assign lo_prod = {{NW{1'b0}}, i_in_beat.key[31:0]} * {32'b0, i_slots};
    assign hi_prod = {{NW{1'b0}}, i_in_beat.key[63:32]} * {32'b0, i_slots};

    always_comb begin
        n_p_valid = r_p_valid;
        if (accept) begin
            n_p_valid = 1'b1;
        end else if (o_push) begin
            n_p_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= n_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_lo        <= lo_prod;
            r_p_hi        <= hi_prod;
            r_p_cmd.req   <= ecdm_pkg::t_req'(i_in_beat.req_type);
            r_p_cmd.tag   <= i_in_beat.key[31:0];
            r_p_cmd.score <= i_in_beat.score_in;
        end
    end

    // high word of hi*n + (lo*n >> 32), always below n
    assign mid    = {1'b0, r_p_hi} + (PW + 1)'(r_p_lo[PW-1:32]);
    assign o_slot = mid[32 + AW - 1:32];
    assign o_cmd  = r_p_cmd;

endmodule

// ===== rtl/ecdm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eval cache back
// Owns the tag/score table: probes, saves, clear sweeps and the result beat.
// ----------------------------------------------------------------------------
module ecdm_back #(
    parameter int DEPTH = ecdm_pkg::DefaultDepth,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  ecdm_pkg::t_cmd                i_cmd,
    input  logic [AW-1:0]                 i_slot,
    output logic                          o_pop,
    input  logic signed [15:0]            i_marker,
    output logic                          o_init_busy,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ecdm_pkg::t_out_beat           o_out_beat
);
    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_SWEEP = 3'b010,
        ST_ACK   = 3'b100
    } t_state;

    ecdm_pkg::t_entry r_mem [DEPTH];
    ecdm_pkg::t_entry r_rd;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_sweep_addr, n_sweep_addr;
    logic                r_sweep_ack, n_sweep_ack;
    logic                r_init, n_init;
    logic signed [15:0]  r_fill, n_fill;

    logic                r_b1_valid, n_b1_valid;
    logic                r_b1_probe, n_b1_probe;
    logic [31:0]         r_b1_tag, n_b1_tag;

    logic                r_o_valid, n_o_valid;
    ecdm_pkg::t_out_beat r_o_beat;

    logic b1_adv;
    logic b1_free;
    logic b1_load;
    logic last;
    logic hit;

    assign b1_adv  = r_b1_valid & (~r_o_valid | ~i_out_stall);
    assign b1_free = ~r_b1_valid | b1_adv;
    assign o_pop   = (r_state == ST_RUN) & ~i_q_empty & b1_free;
    assign last    = (r_sweep_addr == AW'(DEPTH - 1));
    assign hit     = r_b1_probe & (r_rd.tag == r_b1_tag) & (r_rd.score != i_marker);

    always_comb begin
        n_state      = r_state;
        n_sweep_addr = r_sweep_addr;
        n_sweep_ack  = r_sweep_ack;
        n_init       = r_init;
        n_fill       = r_fill;
        b1_load      = 1'b0;
        n_b1_probe   = r_b1_probe;
        n_b1_tag     = r_b1_tag;
        unique case (r_state)
            ST_RUN: begin
                if (o_pop) begin
                    unique case (i_cmd.req)
                        ecdm_pkg::REQ_PROBE: begin
                            b1_load    = 1'b1;
                            n_b1_probe = 1'b1;
                            n_b1_tag   = i_cmd.tag;
                        end
                        ecdm_pkg::REQ_SAVE, ecdm_pkg::REQ_NONE: begin
                            b1_load    = 1'b1;
                            n_b1_probe = 1'b0;
                        end
                        ecdm_pkg::REQ_CLEAR: begin
                            n_state      = ST_SWEEP;
                            n_sweep_addr = '0;
                            n_sweep_ack  = 1'b1;
                            n_fill       = i_marker;
                        end
                        default: begin
                            b1_load    = 1'b1;
                            n_b1_probe = 1'b0;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                n_sweep_addr = r_sweep_addr + 1'b1;
                if (last) begin
                    n_init  = 1'b0;
                    n_state = r_sweep_ack ? ST_ACK : ST_RUN;
                end
            end
            ST_ACK: begin
                // clear acknowledgement waits for room in the read stage
                if (b1_free) begin
                    b1_load    = 1'b1;
                    n_b1_probe = 1'b0;
                    n_state    = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase

        n_b1_valid = r_b1_valid;
        if (b1_load) begin
            n_b1_valid = 1'b1;
        end else if (b1_adv) begin
            n_b1_valid = 1'b0;
        end

        n_o_valid = r_o_valid;
        if (b1_adv) begin
            n_o_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep_addr <= '0;
            r_sweep_ack  <= 1'b0;
            r_init       <= 1'b1;
            r_fill       <= ecdm_pkg::MarkerReset;
            r_b1_valid   <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep_addr <= n_sweep_addr;
            r_sweep_ack  <= n_sweep_ack;
            r_init       <= n_init;
            r_fill       <= n_fill;
            r_b1_valid   <= n_b1_valid;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1_probe <= n_b1_probe;
        r_b1_tag   <= n_b1_tag;
        if (b1_adv) begin
            r_o_beat.hit       <= hit;
            r_o_beat.score_out <= hit ? r_rd.score : i_marker;
        end
    end

    // table: one write port (save or sweep), one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SWEEP) begin
            r_mem[r_sweep_addr] <= '{tag: '0, score: r_fill};
        end else if (o_pop && i_cmd.req == ecdm_pkg::REQ_SAVE) begin
            r_mem[i_slot] <= '{tag: i_cmd.tag, score: i_cmd.score};
        end
        if (o_pop) begin
            r_rd <= r_mem[i_slot];
        end
    end

    assign o_init_busy = r_init;
    assign o_out_valid = r_o_valid;
    assign o_out_beat  = r_o_beat;

endmodule

// ===== rtl/eval_cache_direct_mapped_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eval cache top
// Direct-mapped score cache with multiply-high slot index and apb registers.
// ----------------------------------------------------------------------------
// path: front product register, command queue, table read stage, then output register
// throughput: one probe or save per cycle unless an output stall, a full queue or a sweep holds it
// clear: a table sweep writes every slot, one slot per cycle, then one ack beat
// reset: a sweep writes every slot, no request beat taken meanwhile
// registers reset to 4096 slots in use and marker -32768
module eval_cache_direct_mapped_top #(
    parameter int DEPTH = ecdm_pkg::DefaultDepth
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ecdm_pkg::t_in_beat   i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ecdm_pkg::t_out_beat  o_out_beat,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    localparam int NW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ResetSlots = (4096 > DEPTH) ? DEPTH : 4096;

    logic [ecdm_pkg::EntriesWidth-1:0] r_entries;
    logic signed [15:0]                r_marker;
    logic [NW-1:0]                     r_slots, n_slots;

    logic           cfg_wr;
    logic [31:0]    wr_ent;
    logic           init_busy;
    logic           q_full;
    logic           q_empty;
    logic           push;
    logic           pop;
    ecdm_pkg::t_cmd f_cmd;
    ecdm_pkg::t_cmd q_cmd;
    logic [AW-1:0]  f_slot;
    logic [AW-1:0]  q_slot;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    // slots in use: zero acts as one, anything above the table saturates
    assign wr_ent = 32'(pwdata[ecdm_pkg::EntriesWidth-1:0]);
    always_comb begin
        if (wr_ent == 32'd0) begin
            n_slots = NW'(1);
        end else if (wr_ent > 32'(DEPTH)) begin
            n_slots = NW'(DEPTH);
        end else begin
            n_slots = NW'(wr_ent);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= ecdm_pkg::EntriesReset;
            r_marker  <= ecdm_pkg::MarkerReset;
            r_slots   <= NW'(ResetSlots);
        end else if (cfg_wr) begin
            if (paddr[2] == ecdm_pkg::RegEntries) begin
                r_entries <= pwdata[ecdm_pkg::EntriesWidth-1:0];
                r_slots   <= n_slots;
            end else begin
                r_marker <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == ecdm_pkg::RegMarker) ? {16'b0, r_marker}
                                                      : 32'(r_entries);

    ecdm_front #(
        .DEPTH (DEPTH),
        .NW    (NW),
        .AW    (AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .i_slots     (r_slots),
        .i_init_busy (init_busy),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (f_cmd),
        .o_slot      (f_slot)
    );

    ecdm_queue #(
        .WIDTH ($bits(ecdm_pkg::t_cmd) + AW),
        .QD    (ecdm_pkg::QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cmd, f_slot}),
        .i_pop   (pop),
        .o_data  ({q_cmd, q_slot}),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ecdm_back #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_cmd       (q_cmd),
        .i_slot      (q_slot),
        .o_pop       (pop),
        .i_marker    (r_marker),
        .o_init_busy (init_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule

// ===== verif/tb_eval_cache_direct_mapped_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eval cache testbench
// Drives probe, save, clear and no-op beats through the direct-mapped score cache
// under random input gaps and output stalls, mirrors the table in a local
// model and checks every reply beat in order. Register settings are changed
// over the apb port between phases while the cache is idle.
// ----------------------------------------------------------------------------
module tb_eval_cache_direct_mapped_top;
    import ecdm_pkg::*;

    localparam int DEPTH         = ecdm_pkg::DefaultDepth;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = 12;
    localparam logic [2:0] ADDR_ENTRIES = {RegEntries, 2'b00};
    localparam logic [2:0] ADDR_MARKER  = {RegMarker, 2'b00};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_beat    i_in_beat = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_beat   o_out_beat;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    eval_cache_direct_mapped_top #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_beat (o_out_beat),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- cache model ----------------
    logic [TagWidth-1:0]          cache_tag [DEPTH];
    logic signed [ScoreWidth-1:0] cache_score [DEPTH];
    logic [EntriesWidth-1:0]      cfg_entries = EntriesReset;
    logic signed [ScoreWidth-1:0] cfg_marker = MarkerReset;

    t_out_beat   expected_replies [$];
    logic [63:0] saved_keys [$];
    int          error_count = 0;
    int          cycle_count = 0;

    function automatic int unsigned slot_index(logic [63:0] key);
        logic [127:0] prod;
        int unsigned  n;
        n = 32'(cfg_entries);
        if (n == 0) n = 1;
        if (n > DEPTH) n = DEPTH;
        prod = {64'd0, key} * 128'(n);
        return prod[95:64];
    endfunction

    // applies one request to the model table and returns the reply it owes
    function automatic t_out_beat cache_access(t_in_beat beat);
        t_out_beat   reply;
        int unsigned slot;
        reply.hit       = 1'b0;
        reply.score_out = cfg_marker;
        slot = slot_index(beat.key);
        case (t_req'(beat.req_type))
            REQ_PROBE: begin
                if (cache_tag[slot] == beat.key[31:0] && cache_score[slot] != cfg_marker) begin
                    reply.hit       = 1'b1;
                    reply.score_out = cache_score[slot];
                end
            end
            REQ_SAVE: begin
                cache_tag[slot]   = beat.key[31:0];
                cache_score[slot] = beat.score_in;
            end
            REQ_CLEAR: begin
                for (int i = 0; i < DEPTH; i++) begin
                    cache_tag[i]   = '0;
                    cache_score[i] = cfg_marker;
                end
            end
            default: ;
        endcase
        return reply;
    endfunction

    // ---------------- reply side ----------------
    task automatic report_mismatch(string what);
        // keep the log bounded when something is badly broken
        if (error_count < 100) $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    always @(posedge i_clk) begin : check_reply
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_replies.size() == 0) begin
                report_mismatch($sformatf("unexpected beat hit=%0b score=%0d",
                                          o_out_beat.hit, o_out_beat.score_out));
            end else begin
                want = expected_replies.pop_front();
                if (o_out_beat.hit !== want.hit)
                    report_mismatch($sformatf("hit got %0b want %0b",
                                              o_out_beat.hit, want.hit));
                if (o_out_beat.score_out !== want.score_out)
                    report_mismatch($sformatf("score got %0d want %0d",
                                              o_out_beat.score_out, want.score_out));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    int  out_phase_left = 0;
    int  out_stall_left = 0;
    bit  out_calm = 1'b0;

    always @(posedge i_clk) begin : out_stall_gen
        int r;
        if (out_phase_left == 0) begin
            out_calm       = ($urandom_range(0, 3) == 0);
            out_phase_left = $urandom_range(50, 300);
        end
        out_phase_left--;
        r = $urandom_range(0, 99);
        if (out_stall_left > 0) begin
            i_out_stall <= 1'b1;
            out_stall_left--;
        end else if (out_calm || r < 70) begin
            i_out_stall <= 1'b0;
        end else if (r < 97) begin
            i_out_stall    <= 1'b1;
            out_stall_left = $urandom_range(0, 2);
        end else begin
            i_out_stall    <= 1'b1;
            out_stall_left = $urandom_range(10, 40);
        end
    end

    // ---------------- request side ----------------
    int in_phase_left = 0;
    bit in_calm = 1'b0;

    function automatic int next_gap();
        int r;
        if (in_phase_left == 0) begin
            in_calm       = ($urandom_range(0, 3) == 0);
            in_phase_left = $urandom_range(20, 120);
        end
        in_phase_left--;
        if (in_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // valid stays high after a beat so the next call can follow without a bubble
    task automatic send_req(input t_req req, input logic [63:0] key,
                            input logic signed [ScoreWidth-1:0] score);
        t_in_beat beat;
        int       gap;
        beat.req_type = req;
        beat.key      = key;
        beat.score_in = score;
        gap = next_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= beat;
        do @(posedge i_clk); while (o_in_stall);
        expected_replies.push_back(cache_access(beat));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == RegMarker) cfg_marker = data[ScoreWidth-1:0];
        else cfg_entries = data[EntriesWidth-1:0];
        @(posedge i_clk);
    endtask

    // upper bits carry junk, only the low field width is meaningful
    task automatic set_config(input int unsigned entries, input logic signed [15:0] marker);
        wait_idle();
        write_reg(ADDR_ENTRIES, ($urandom() & ~32'h1FFF) | (entries & 32'h1FFF));
        write_reg(ADDR_MARKER, {16'($urandom_range(0, 16'hFFFF)), marker});
    endtask

    function automatic logic [63:0] rand_key();
        logic [63:0] key;
        int          r;
        key = {$urandom(), $urandom()};
        r = $urandom_range(0, 19);
        if (r == 0) key[31:0] = '0;
        else if (r == 1) key[31:0] = '1;
        else if (r == 2) key[63:32] = '0;
        else if (r == 3) key[63:32] = '1;
        return key;
    endfunction

    function automatic logic signed [15:0] rand_score();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return cfg_marker;
        if (r < 13) return 16'sh7FFF;
        if (r < 16) return 16'sh8000;
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    // ---------------- tests ----------------
    task automatic test_empty_table();
        // tag zero matches after reset but the score is the marker
        send_req(REQ_PROBE, 64'd0, 16'sd0);
        send_req(REQ_PROBE, '1, 16'sh7FFF);
    endtask

    task automatic test_basic_ops();
        send_req(REQ_SAVE, 64'd0, 16'sd1);
        send_req(REQ_PROBE, 64'd0, 16'sd0);
        send_req(REQ_SAVE, '1, 16'sh7FFF);
        send_req(REQ_PROBE, '1, 16'sd0);
        // same slot, different tag
        send_req(REQ_PROBE, 64'hFFF0_0000_1234_5678, 16'sd0);
        // a saved score equal to the marker reads back as empty
        send_req(REQ_SAVE, 64'h8000_0000_0000_0001, 16'sh8000);
        send_req(REQ_PROBE, 64'h8000_0000_0000_0001, 16'sd0);
        send_req(REQ_SAVE, 64'h8000_0000_0000_0001, 16'sh8001);
        send_req(REQ_PROBE, 64'h8000_0000_0000_0001, 16'sd0);
        send_req(REQ_NONE, 64'h8000_0000_0000_0001, 16'sh5A5A);
        send_req(REQ_PROBE, 64'h8000_0000_0000_0001, 16'sd0);
        send_req(REQ_CLEAR, 64'hDEAD_BEEF_0000_0001, 16'sd3);
        send_req(REQ_PROBE, '1, 16'sd0);
    endtask

    task automatic test_register_corners();
        // zero slots in use acts as one: every key maps to slot zero
        set_config(0, MarkerReset);
        send_req(REQ_SAVE, 64'h0123_4567_89AB_CDEF, 16'sd77);
        send_req(REQ_PROBE, 64'hFEDC_BA98_89AB_CDEF, 16'sd0);
        // too many slots saturate at the table size
        set_config(8191, MarkerReset);
        send_req(REQ_SAVE, '1, 16'sd9);
        send_req(REQ_PROBE, '1, 16'sd0);
        // marker change leaves stored scores alone
        set_config(DEPTH, 16'sd9);
        send_req(REQ_PROBE, '1, 16'sd0);
        send_req(REQ_PROBE, 64'h0000_0001_0000_0000, 16'sd0);
        send_req(REQ_CLEAR, '0, 16'sd0);
        send_req(REQ_PROBE, 64'h0000_0001_0000_0000, 16'sd0);
    endtask

    task automatic random_phase(input int unsigned entries, input logic signed [15:0] marker,
                                input int count);
        logic [63:0] key;
        int          r;
        int          clears_left;
        clears_left = 3;
        set_config(entries, marker);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                if (saved_keys.size() > 0 && $urandom_range(0, 9) < 7) begin
                    key = saved_keys[$urandom_range(0, saved_keys.size() - 1)];
                    if ($urandom_range(0, 4) == 0) key[$urandom_range(0, 63)] ^= 1'b1;
                end else begin
                    key = rand_key();
                end
                send_req(REQ_PROBE, key, 16'($urandom_range(0, 16'hFFFF)));
            end else if (r < 90) begin
                if (saved_keys.size() > 0 && $urandom_range(0, 1) == 0) begin
                    key = saved_keys[$urandom_range(0, saved_keys.size() - 1)];
                end else begin
                    key = rand_key();
                    saved_keys.push_back(key);
                    if (saved_keys.size() > 48) void'(saved_keys.pop_front());
                end
                send_req(REQ_SAVE, key, rand_score());
            end else if (r < 91 && clears_left > 0) begin
                clears_left--;
                send_req(REQ_CLEAR, rand_key(), 16'($urandom_range(0, 16'hFFFF)));
            end else begin
                send_req(REQ_NONE, rand_key(), 16'($urandom_range(0, 16'hFFFF)));
            end
        end
    endtask

    task automatic test_random_traffic();
        random_phase(DEPTH, MarkerReset, 200);
        random_phase(1, 16'($urandom_range(0, 16'hFFFF)), 200);
        random_phase(2, 16'sd0, 200);
        random_phase(8191, 16'sh7FFF, 200);
        random_phase(3, 16'($urandom_range(0, 16'hFFFF)), 200);
        random_phase($urandom_range(0, 8191), 16'($urandom_range(0, 16'hFFFF)), 200);
        random_phase($urandom_range(4, 64), 16'sh8000, 200);
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            cache_tag[i]   = '0;
            cache_score[i] = MarkerReset;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_basic_ops();
        test_register_corners();
        test_random_traffic();
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== eval_cache_direct_mapped_top.f =====
rtl/ecdm_pkg.sv
rtl/ecdm_queue.sv
rtl/ecdm_front.sv
rtl/ecdm_back.sv
rtl/eval_cache_direct_mapped_top.sv
verif/tb_eval_cache_direct_mapped_top.sv
